// ===== hw/rtl/ias_pkg.sv =====
`timescale 1ns / 1ps

package ias_pkg;

	// field widths of the request and result channels
	localparam int REQ_W   = 3;
	localparam int IDX_W   = 7;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int POS_W   = 6;
	localparam int COUNT_W = 7;
	localparam int CAP_W   = 7;

	localparam int DEPTH_DEF = 64;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// request types
	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd2;
	localparam logic [REQ_W-1:0] REQ_GET    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SET    = 3'd4;
	localparam logic [REQ_W-1:0] REQ_SORTED = 3'd5;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

	// walk pointer operations
	localparam logic [2:0] PTR_HOLD = 3'd0;
	localparam logic [2:0] PTR_INC  = 3'd1;
	localparam logic [2:0] PTR_DEC  = 3'd2;
	localparam logic [2:0] PTR_IDX  = 3'd3;
	localparam logic [2:0] PTR_LAST = 3'd4;
	localparam logic [2:0] PTR_ZERO = 3'd5;

	// memory write modes
	localparam logic [2:0] WR_NONE     = 3'd0;
	localparam logic [2:0] WR_UP       = 3'd1;
	localparam logic [2:0] WR_DOWN     = 3'd2;
	localparam logic [2:0] WR_VAL_IDX  = 3'd3;
	localparam logic [2:0] WR_VAL_ZERO = 3'd4;
	localparam logic [2:0] WR_VAL_UP   = 3'd5;
	localparam logic [2:0] WR_TMP_RP   = 3'd6;

	// count operations
	localparam logic [1:0] CNT_HOLD = 2'd0;
	localparam logic [1:0] CNT_INC  = 2'd1;
	localparam logic [1:0] CNT_DEC  = 2'd2;

	typedef struct packed {
		logic              load;
		logic              rd_en;
		logic [2:0]        ptr_op;
		logic [2:0]        wr_mode;
		logic              cap_data;
		logic              cap_tmp;
		logic              cap_pos;
		logic              set_status;
		logic [STAT_W-1:0] status;
		logic [1:0]        cnt_op;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             idx_le_cnt;
		logic             idx_lt_cnt;
		logic             full;
		logic             cnt_zero;
		logic             ptr_eq_idx;
		logic             rp_is_zero;
		logic             rp_is_last;
		logic             rd_valid;
		logic             rd_eq;
		logic             rd_gt;
	} sts_t;

endpackage

// ===== hw/rtl/ias_req_if.sv =====
`timescale 1ns / 1ps

interface ias_req_if import ias_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [REQ_W-1:0]        req_type;
	logic [IDX_W-1:0]        elem_index;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output req_type, output elem_index, output value,
		input ready);
	modport sink (input valid, input req_type, input elem_index, input value,
		output ready);
endinterface

// ===== hw/rtl/ias_rsp_if.sv =====
`timescale 1ns / 1ps

interface ias_rsp_if import ias_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic signed [VAL_W-1:0] data;
	logic [POS_W-1:0]        position;
	logic [COUNT_W-1:0]      count;

	modport source (output valid, output status, output data, output position,
		output count, input ready);
	modport sink (input valid, input status, input data, input position,
		input count, output ready);
endinterface

// ===== hw/rtl/ias_ram.sv =====
`timescale 1ns / 1ps

module ias_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/ias_ctrl.sv =====
`timescale 1ns / 1ps

module ias_ctrl import ias_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	localparam logic [4:0] S_IDLE       = 5'd0;
	localparam logic [4:0] S_DECODE     = 5'd1;
	localparam logic [4:0] S_INS_SHIFT  = 5'd2;
	localparam logic [4:0] S_INS_LAST   = 5'd3;
	localparam logic [4:0] S_INS_PUT    = 5'd4;
	localparam logic [4:0] S_DEL_FIRST  = 5'd5;
	localparam logic [4:0] S_DEL_CAPT   = 5'd6;
	localparam logic [4:0] S_DEL_SHIFT  = 5'd7;
	localparam logic [4:0] S_SRCH_FIRST = 5'd8;
	localparam logic [4:0] S_SRCH       = 5'd9;
	localparam logic [4:0] S_SRCH_SW1   = 5'd10;
	localparam logic [4:0] S_SRCH_SW2   = 5'd11;
	localparam logic [4:0] S_GET_RD     = 5'd12;
	localparam logic [4:0] S_GET_CAP    = 5'd13;
	localparam logic [4:0] S_SINS_FIRST = 5'd14;
	localparam logic [4:0] S_SINS       = 5'd15;
	localparam logic [4:0] S_SINS_PUT0  = 5'd16;
	localparam logic [4:0] S_FINISH     = 5'd17;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FINISH;
				unique case (sts.req)
					REQ_INSERT: begin
						if (!sts.idx_le_cnt) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_RANGE;
						end else if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else if (sts.idx_lt_cnt) begin
							cmd.ptr_op = PTR_LAST;
							state_d    = S_INS_SHIFT;
						end else begin
							state_d = S_INS_PUT;
						end
					end
					REQ_DELETE: begin
						if (!sts.idx_lt_cnt) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_RANGE;
						end else begin
							cmd.ptr_op = PTR_IDX;
							state_d    = S_DEL_FIRST;
						end
					end
					REQ_SEARCH: begin
						if (sts.cnt_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_MISS;
						end else begin
							cmd.ptr_op = PTR_ZERO;
							state_d    = S_SRCH_FIRST;
						end
					end
					REQ_GET: begin
						if (!sts.idx_lt_cnt) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_RANGE;
						end else begin
							cmd.ptr_op = PTR_IDX;
							state_d    = S_GET_RD;
						end
					end
					REQ_SET: begin
						if (!sts.idx_lt_cnt) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_RANGE;
						end else begin
							cmd.wr_mode = WR_VAL_IDX;
						end
					end
					REQ_SORTED: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else if (sts.cnt_zero) begin
							cmd.wr_mode = WR_VAL_ZERO;
							cmd.cnt_op  = CNT_INC;
						end else begin
							cmd.ptr_op = PTR_LAST;
							state_d    = S_SINS_FIRST;
						end
					end
					default: begin
						// unused request types finish with an ok status
						state_d = S_FINISH;
					end
				endcase
			end
			S_INS_SHIFT: begin
				// read walks down, each word read is written back one slot higher
				cmd.rd_en = 1'b1;
				if (sts.rd_valid) begin
					cmd.wr_mode = WR_UP;
				end
				if (sts.ptr_eq_idx) begin
					state_d = S_INS_LAST;
				end else begin
					cmd.ptr_op = PTR_DEC;
				end
			end
			S_INS_LAST: begin
				cmd.wr_mode = WR_UP;
				state_d     = S_INS_PUT;
			end
			S_INS_PUT: begin
				cmd.wr_mode = WR_VAL_IDX;
				cmd.cnt_op  = CNT_INC;
				state_d     = S_FINISH;
			end
			S_DEL_FIRST: begin
				cmd.rd_en  = 1'b1;
				cmd.ptr_op = PTR_INC;
				state_d    = S_DEL_CAPT;
			end
			S_DEL_CAPT: begin
				cmd.cap_data = 1'b1;
				if (sts.rp_is_last) begin
					cmd.cnt_op = CNT_DEC;
					state_d    = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.ptr_op = PTR_INC;
					state_d    = S_DEL_SHIFT;
				end
			end
			S_DEL_SHIFT: begin
				cmd.wr_mode = WR_DOWN;
				if (sts.rp_is_last) begin
					cmd.cnt_op = CNT_DEC;
					state_d    = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.ptr_op = PTR_INC;
				end
			end
			S_SRCH_FIRST: begin
				cmd.rd_en  = 1'b1;
				cmd.ptr_op = PTR_INC;
				state_d    = S_SRCH;
			end
			S_SRCH: begin
				// entry 0 is kept for the swap
				cmd.cap_tmp = sts.rp_is_zero;
				if (sts.rd_eq) begin
					cmd.cap_pos = 1'b1;
					state_d     = S_SRCH_SW1;
				end else if (sts.rp_is_last) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_MISS;
					state_d        = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.ptr_op = PTR_INC;
				end
			end
			S_SRCH_SW1: begin
				cmd.wr_mode = WR_TMP_RP;
				state_d     = S_SRCH_SW2;
			end
			S_SRCH_SW2: begin
				cmd.wr_mode = WR_VAL_ZERO;
				state_d     = S_FINISH;
			end
			S_GET_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_GET_CAP;
			end
			S_GET_CAP: begin
				cmd.cap_data = 1'b1;
				state_d      = S_FINISH;
			end
			S_SINS_FIRST: begin
				cmd.rd_en  = 1'b1;
				cmd.ptr_op = PTR_DEC;
				state_d    = S_SINS;
			end
			S_SINS: begin
				if (sts.rd_gt) begin
					cmd.wr_mode = WR_UP;
					if (sts.rp_is_zero) begin
						state_d = S_SINS_PUT0;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.ptr_op = PTR_DEC;
					end
				end else begin
					// equal entries stay in front of the new value
					cmd.wr_mode = WR_VAL_UP;
					cmd.cnt_op  = CNT_INC;
					state_d     = S_FINISH;
				end
			end
			S_SINS_PUT0: begin
				cmd.wr_mode = WR_VAL_ZERO;
				cmd.cnt_op  = CNT_INC;
				state_d     = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while still held");

	a_decode_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECODE) |-> $past(in_valid && in_ready))
		else $error("decode entered without an accepted request");

	a_dec_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cnt_op == CNT_DEC) |-> !sts.cnt_zero)
		else $error("count decremented below zero");
`endif

endmodule

// ===== hw/rtl/ias_dp.sv =====
`timescale 1ns / 1ps

module ias_dp import ias_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CAP_W-1:0]        cfg_wdata,
	input  logic [REQ_W-1:0]        in_req_type,
	input  logic [IDX_W-1:0]        in_elem_index,
	input  logic signed [VAL_W-1:0] in_value,
	output logic [STAT_W-1:0]       out_status,
	output logic signed [VAL_W-1:0] out_data,
	output logic [POS_W-1:0]        out_position,
	output logic [COUNT_W-1:0]      out_count,
	input  cmd_t                    cmd,
	output sts_t                    sts
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int E_W   = CNT_W + IDX_W;

	logic [CAP_W-1:0]        cap_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [AW-1:0]           ptr_q;
	logic [AW-1:0]           rp_q;
	logic                    rv_q;
	logic [REQ_W-1:0]        req_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [VAL_W-1:0] val_q;
	logic [VAL_W-1:0]        tmp_q;
	logic [STAT_W-1:0]       res_status_q;
	logic signed [VAL_W-1:0] res_data_q;
	logic [POS_W-1:0]        res_pos_q;
	logic [STAT_W-1:0]       out_status_q;
	logic signed [VAL_W-1:0] out_data_q;
	logic [POS_W-1:0]        out_pos_q;
	logic [COUNT_W-1:0]      out_count_q;

	logic [VAL_W-1:0] rd_data;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [VAL_W-1:0] ram_wdata;

	logic [E_W-1:0] cnt_e;
	logic [E_W-1:0] idx_e;
	logic [E_W-1:0] cap_e;
	logic [E_W-1:0] lim_e;
	logic [AW-1:0]  ptr_last;

	assign cnt_e    = E_W'(cnt_q);
	assign idx_e    = E_W'(idx_q);
	assign cap_e    = E_W'(cap_q);
	// capacity above the memory depth acts as the depth
	assign lim_e    = (cap_e > E_W'(DEPTH)) ? E_W'(DEPTH) : cap_e;
	assign ptr_last = AW'(cnt_q - CNT_W'(1));

	assign sts.req        = req_q;
	assign sts.idx_le_cnt = (idx_e <= cnt_e);
	assign sts.idx_lt_cnt = (idx_e < cnt_e);
	assign sts.full       = (cnt_e >= lim_e);
	assign sts.cnt_zero   = (cnt_q == '0);
	assign sts.ptr_eq_idx = (E_W'(ptr_q) == idx_e);
	assign sts.rp_is_zero = (rp_q == '0);
	assign sts.rp_is_last = (E_W'(rp_q) == cnt_e - E_W'(1));
	assign sts.rd_valid   = rv_q;
	assign sts.rd_eq      = (rd_data == $unsigned(val_q));
	assign sts.rd_gt      = ($signed(rd_data) > val_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rp_q;
		ram_wdata = rd_data;
		unique case (cmd.wr_mode)
			WR_UP: begin
				ram_we    = 1'b1;
				ram_waddr = rp_q + AW'(1);
			end
			WR_DOWN: begin
				ram_we    = 1'b1;
				ram_waddr = rp_q - AW'(1);
			end
			WR_VAL_IDX: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(idx_q);
				ram_wdata = $unsigned(val_q);
			end
			WR_VAL_ZERO: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = $unsigned(val_q);
			end
			WR_VAL_UP: begin
				ram_we    = 1'b1;
				ram_waddr = rp_q + AW'(1);
				ram_wdata = $unsigned(val_q);
			end
			WR_TMP_RP: begin
				ram_we    = 1'b1;
				ram_wdata = tmp_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ias_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_en),
		.raddr(ptr_q),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			cnt_q <= '0;
			ptr_q <= '0;
			rv_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			rv_q <= cmd.rd_en;
			case (cmd.cnt_op)
				CNT_INC: cnt_q <= cnt_q + CNT_W'(1);
				CNT_DEC: cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
			unique case (cmd.ptr_op)
				PTR_INC:  ptr_q <= ptr_q + AW'(1);
				PTR_DEC:  ptr_q <= ptr_q - AW'(1);
				PTR_IDX:  ptr_q <= AW'(idx_q);
				PTR_LAST: ptr_q <= ptr_last;
				PTR_ZERO: ptr_q <= '0;
				default:  ptr_q <= ptr_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rp_q <= ptr_q;
		end
		if (cmd.load) begin
			req_q        <= in_req_type;
			idx_q        <= in_elem_index;
			val_q        <= in_value;
			res_status_q <= ST_OK;
			res_data_q   <= '0;
			res_pos_q    <= '0;
		end else begin
			if (cmd.set_status) begin
				res_status_q <= cmd.status;
			end
			if (cmd.cap_data) begin
				res_data_q <= $signed(rd_data);
			end
			if (cmd.cap_pos) begin
				res_pos_q <= POS_W'(rp_q);
			end
		end
		if (cmd.cap_tmp) begin
			tmp_q <= rd_data;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_data_q   <= res_data_q;
			out_pos_q    <= res_pos_q;
			out_count_q  <= COUNT_W'(cnt_q);
		end
	end

	assign out_status   = out_status_q;
	assign out_data     = out_data_q;
	assign out_position = out_pos_q;
	assign out_count    = out_count_q;

`ifndef ASSERT_OFF
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && cmd.rd_en) |-> (ram_waddr != ptr_q))
		else $error("read and write hit the same entry in one cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		E_W'(cnt_q) <= E_W'(DEPTH))
		else $error("entry count beyond memory depth");

	a_inc_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cnt_op == CNT_INC) |-> !sts.full)
		else $error("entry added to a full list");
`endif

endmodule

// ===== hw/rtl/indexed_array_store_top.sv =====
`timescale 1ns / 1ps
// channel | modport       | moves
// req     | ias_req_if    | request: req_type, elem_index, value
// rsp     | ias_rsp_if    | result: status, data, position, count
// cfg     | cfg_we/wdata  | capacity register write, no read-back
//
// one request at a time: the request side is ready only while the controller is idle, and
// a new request is taken once the previous result has moved to the output register
// the walk moves one entry per cycle through the single read port of the entry memory
// reset clears the count and restores capacity 64; entries hold no reset value
// a finished result waits in the output register, a new request is taken meanwhile

module indexed_array_store_top import ias_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	ias_req_if.sink          req,
	ias_rsp_if.source        rsp
);

	cmd_t cmd;
	sts_t sts;

	ias_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ias_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_req_type  (req.req_type),
		.in_elem_index(req.elem_index),
		.in_value     (req.value),
		.out_status   (rsp.status),
		.out_data     (rsp.data),
		.out_position (rsp.position),
		.out_count    (rsp.count),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import ias_pkg::*;

	localparam int LIST_DEPTH = DEPTH_DEF;
	localparam int MAX_GAP    = 12;
	localparam int LONG_HOLD  = 400;

	// request types the block leaves undecoded
	localparam logic [REQ_W-1:0] REQ_NONE_A = 3'd6;
	localparam logic [REQ_W-1:0] REQ_NONE_B = 3'd7;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [VAL_W-1:0] data;
		logic [POS_W-1:0]        position;
		logic [COUNT_W-1:0]      count;
	} list_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	ias_req_if req_ch ();
	ias_rsp_if rsp_ch ();

	indexed_array_store_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// predicted list contents
	logic signed [VAL_W-1:0] list_mem [LIST_DEPTH];
	int                      list_count;
	int                      list_cap;
	list_result_t            list_result_q [$];

	int error_count;
	bit idle_on;
	int hold_off;
	int pending_gap;
	bit req_held;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
		$display("ERROR at %0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
		error_count++;
	endtask

	task automatic apply_list_request(input logic [REQ_W-1:0] op, input logic [IDX_W-1:0] idx,
		input logic signed [VAL_W-1:0] val, output list_result_t res);
		int                      i;
		int                      lim;
		bit                      found;
		logic signed [VAL_W-1:0] t;
		res = '0;
		res.status = ST_OK;
		lim = (list_cap > LIST_DEPTH) ? LIST_DEPTH : list_cap;
		case (op)
			REQ_INSERT: begin
				// position check wins over the full check
				if (idx > list_count)
					res.status = ST_RANGE;
				else if (list_count >= lim)
					res.status = ST_FULL;
				else begin
					for (i = list_count; i > idx; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[idx] = val;
					list_count++;
				end
			end
			REQ_DELETE: begin
				if (idx >= list_count)
					res.status = ST_RANGE;
				else begin
					res.data = list_mem[idx];
					for (i = idx; i + 1 < list_count; i++)
						list_mem[i] = list_mem[i+1];
					list_count--;
				end
			end
			REQ_SEARCH: begin
				res.status = ST_MISS;
				found = 1'b0;
				for (i = 0; i < list_count && !found; i++) begin
					if (list_mem[i] == val) begin
						t = list_mem[0];
						list_mem[0] = list_mem[i];
						list_mem[i] = t;
						res.position = i[POS_W-1:0];
						res.status = ST_OK;
						found = 1'b1;
					end
				end
			end
			REQ_GET: begin
				if (idx >= list_count)
					res.status = ST_RANGE;
				else
					res.data = list_mem[idx];
			end
			REQ_SET: begin
				if (idx >= list_count)
					res.status = ST_RANGE;
				else
					list_mem[idx] = val;
			end
			REQ_SORTED: begin
				if (list_count >= lim)
					res.status = ST_FULL;
				else begin
					// equal entries stay ahead of the new one
					i = list_count;
					while (i > 0 && list_mem[i-1] > val) begin
						list_mem[i] = list_mem[i-1];
						i--;
					end
					list_mem[i] = val;
					list_count++;
				end
			end
			default: ;
		endcase
		res.count = list_count[COUNT_W-1:0];
	endtask

	// entered at a falling edge, returns at the falling edge after the accept
	task automatic send_request(input logic [REQ_W-1:0] op, input logic [IDX_W-1:0] idx,
		input logic signed [VAL_W-1:0] val);
		list_result_t res;
		if (pending_gap > 0)
			repeat (pending_gap) @(negedge clk);
		req_ch.req_type   <= op;
		req_ch.elem_index <= idx;
		req_ch.value      <= val;
		req_ch.valid      <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		apply_list_request(op, idx, val, res);
		list_result_q.push_back(res);
		@(negedge clk);
		pending_gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (pending_gap > 0) begin
			req_ch.valid <= 1'b0;
			req_held = 1'b0;
		end else
			req_held = 1'b1;
	endtask

	task automatic wait_for_results();
		int n;
		n = 0;
		if (req_held) begin
			req_ch.valid <= 1'b0;
			req_held = 1'b0;
		end
		do begin
			@(negedge clk);
			n++;
		end while (list_result_q.size() != 0 && n < 20000);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_we    <= 1'b0;
		list_cap = int'(cap);
	endtask

	task automatic send_random_request(input int insert_pct);
		int                      r;
		logic [REQ_W-1:0]        op;
		logic [IDX_W-1:0]        idx;
		logic signed [VAL_W-1:0] val;
		r = $urandom_range(0, 99);
		if (r < 3)
			op = $urandom_range(0, 1) ? REQ_NONE_A : REQ_NONE_B;
		else if (r < 3 + insert_pct)
			op = $urandom_range(0, 1) ? REQ_INSERT : REQ_SORTED;
		else begin
			case ($urandom_range(0, 3))
				0: op = REQ_DELETE;
				1: op = REQ_SEARCH;
				2: op = REQ_GET;
				default: op = REQ_SET;
			endcase
		end
		if ($urandom_range(0, 99) < 15)
			idx = IDX_W'($urandom_range(0, 127));
		else if (op == REQ_INSERT)
			idx = IDX_W'($urandom_range(0, list_count));
		else if (list_count > 0)
			idx = IDX_W'($urandom_range(0, list_count - 1));
		else
			idx = '0;
		case ($urandom_range(0, 3))
			0, 1: val = $signed($urandom_range(0, 15)) - 32'sd8;
			2: val = $urandom;
			default: val = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		endcase
		// mostly search for keys that are present
		if (op == REQ_SEARCH && list_count > 0 && $urandom_range(0, 99) < 70)
			val = list_mem[$urandom_range(0, list_count - 1)];
		send_request(op, idx, val);
	endtask

	task automatic test_directed_requests();
		send_request(REQ_GET, 7'd0, 32'sd0);
		send_request(REQ_DELETE, 7'd0, 32'sd0);
		send_request(REQ_SEARCH, 7'd0, 32'sd0);
		send_request(REQ_INSERT, 7'd1, 32'sd9);
		send_request(REQ_INSERT, 7'd0, 32'sh7fffffff);
		send_request(REQ_INSERT, 7'd1, 32'sh80000000);
		send_request(REQ_INSERT, 7'd0, 32'sd0);
		send_request(REQ_INSERT, 7'd1, -32'sd1);
		send_request(REQ_GET, 7'd3, 32'sd0);
		send_request(REQ_GET, 7'd4, 32'sd0);
		send_request(REQ_GET, 7'd127, 32'sd0);
		send_request(REQ_SET, 7'd2, 32'sd5);
		send_request(REQ_SET, 7'd4, 32'sd6);
		send_request(REQ_SEARCH, 7'd0, 32'sh80000000);
		send_request(REQ_SEARCH, 7'd0, 32'sd12345);
		send_request(REQ_SORTED, 7'd99, 32'sd5);
		send_request(REQ_SORTED, 7'd0, 32'sh80000000);
		send_request(REQ_DELETE, 7'd6, 32'sd0);
		send_request(REQ_DELETE, 7'd0, 32'sd0);
		send_request(REQ_DELETE, 7'd4, 32'sd0);
		send_request(REQ_DELETE, 7'd100, 32'sd0);
		send_request(REQ_NONE_A, 7'd127, 32'shffffffff);
		send_request(REQ_NONE_B, 7'd0, 32'sd0);
	endtask

	task automatic test_zero_capacity();
		wait_for_results();
		write_capacity(7'd0);
		send_request(REQ_INSERT, IDX_W'(list_count + 1), 32'sd1);
		send_request(REQ_INSERT, 7'd0, 32'sd1);
		send_request(REQ_SORTED, 7'd0, 32'sd1);
	endtask

	task automatic test_backpressure();
		wait_for_results();
		idle_on = 1'b0;
		hold_off = LONG_HOLD;
		repeat (10) send_random_request(40);
		wait_for_results();
		idle_on = 1'b1;
	endtask

	task automatic test_random_phase(input logic [CAP_W-1:0] cap, input int insert_pct,
		input int items, input bit idle);
		wait_for_results();
		write_capacity(cap);
		idle_on = idle;
		repeat (items) send_random_request(insert_pct);
	endtask

	task automatic check_result();
		list_result_t exp;
		if (list_result_q.size() == 0)
			report_mismatch("result with no request pending, status", 0, rsp_ch.status);
		else begin
			exp = list_result_q.pop_front();
			if (rsp_ch.status !== exp.status)
				report_mismatch("status", exp.status, rsp_ch.status);
			if (rsp_ch.data !== exp.data)
				report_mismatch("data", exp.data, rsp_ch.data);
			if (rsp_ch.position !== exp.position)
				report_mismatch("position", exp.position, rsp_ch.position);
			if (rsp_ch.count !== exp.count)
				report_mismatch("count", exp.count, rsp_ch.count);
		end
	endtask

	// result side: random stalls, one long hold when asked
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off > 0) begin
				stall = hold_off;
				hold_off = 0;
			end else
				stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			check_result();
			@(negedge clk);
		end
	end

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = '0;
		req_ch.elem_index = '0;
		req_ch.value      = '0;
		idle_on           = 1'b1;
		hold_off          = 0;
		pending_gap       = 0;
		req_held          = 1'b0;
		error_count       = 0;
		list_count        = 0;
		list_cap          = int'(CAP_RESET);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_requests();
		test_zero_capacity();
		test_backpressure();
		// capacity above the depth, filled to the top
		test_random_phase(7'd127, 55, 200, 1'b1);
		test_random_phase(7'd64, 15, 150, 1'b0);
		// capacity likely below the current count
		test_random_phase(7'd3, 40, 120, 1'b1);
		test_random_phase(7'd0, 40, 40, 1'b1);
		test_random_phase(7'd1, 40, 80, 1'b1);
		test_random_phase(CAP_W'($urandom_range(1, 127)), 35, 200, 1'b1);
		test_random_phase(7'd64, 30, 160, 1'b1);

		wait_for_results();
		repeat (80) @(negedge clk);
		if (list_result_q.size() != 0)
			report_mismatch("results still outstanding", 0, list_result_q.size());
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
